[hw/rtl/fpalu_pkg.sv]
// ----------------------------------------------------------------------------
// fpalu_pkg
// Shared types and constants of the Q24.8 fixed-point unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fpalu_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int DATA_WIDTH = 32;
  localparam int CMD_W      = 4;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  // divide numerator is ((|a| << frac) * 2 + |b|), divisor is 2 * |b|
  localparam int NUM_W      = DATA_WIDTH + FRAC_BITS + 1;
  localparam int DEN_W      = DATA_WIDTH + 1;
  localparam int REM_W      = DEN_W + 1;
  localparam int DIV_STEPS  = NUM_W;
  localparam int STAGES     = DIV_STEPS + 2;

  localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 4'd0,
    CMD_SUB     = 4'd1,
    CMD_MUL     = 4'd2,
    CMD_DIV     = 4'd3,
    CMD_CMP     = 4'd4,
    CMD_MIN     = 4'd5,
    CMD_MAX     = 4'd6,
    CMD_INC     = 4'd7,
    CMD_DEC     = 4'd8,
    CMD_FROMINT = 4'd9,
    CMD_TOINT   = 4'd10
  } cmd_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] result;
    logic                  less;
    logic                  equal;
    logic                  greater;
    logic                  overflow;
    logic                  divide_by_zero;
  } res_t;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic                    neg;
    logic                    dz;
    logic signed [DATA_WIDTH-1:0] a;
    logic signed [DATA_WIDTH-1:0] b;
    logic [DATA_WIDTH-1:0]   ma;
    logic [DATA_WIDTH-1:0]   mb;
    logic [DEN_W-1:0]        den;
    logic [REM_W-1:0]        rem;
    logic [NUM_W-1:0]        num;
    logic [NUM_W-1:0]        quo;
    logic [PROD_W-1:0]       prod;
    logic [DATA_WIDTH-1:0]   sres;
    logic                    lt;
    logic                    eq;
    logic                    gt;
    logic                    ovf;
  } pipe_t;

endpackage

`default_nettype wire

[hw/rtl/fpalu_in_if.sv]
// ----------------------------------------------------------------------------
// fpalu_in_if
// Command channel: opcode and two raw operands.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpalu_in_if;
  logic                valid;
  logic                ready;
  logic [3:0]          command;
  logic signed [31:0]  operand_a;
  logic signed [31:0]  operand_b;

  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

`default_nettype wire

[hw/rtl/fpalu_out_if.sv]
// ----------------------------------------------------------------------------
// fpalu_out_if
// Result channel: raw result and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpalu_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  result;
  logic                less;
  logic                equal;
  logic                greater;
  logic                overflow;
  logic                divide_by_zero;

  modport source (output valid, result, less, equal, greater, overflow, divide_by_zero,
                  input ready);
  modport sink   (input valid, result, less, equal, greater, overflow, divide_by_zero,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/fixed_point_q24_8_alu.sv]
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Signed Q24.8 arithmetic unit with saturation, pipelined divide.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_chan   in   valid/ready    command, operand_a, operand_b
//  out_chan  out  valid/ready    result, less, equal, greater, overflow,
//                                divide_by_zero
//
//  one item per cycle while the skid entry is empty; an item passes through the
//  STAGES pipeline registers and then the main output register; the restoring
//  divider yields one quotient bit per stage (41 stages)
//  every command runs the full pipe so results leave in order
//  a two-entry output register (main plus skid) absorbs a stall; the pipe
//  freezes only while the skid entry is full
//  synchronous active-low reset clears valid bits only
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_q24_8_alu
  import fpalu_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  fpalu_in_if.sink    in_chan,
  fpalu_out_if.source out_chan
);

  pipe_t s_r   [STAGES];
  pipe_t s_nxt [STAGES];
  logic  v_r   [STAGES];

  res_t  fin;
  res_t  main_r, skid_r;
  logic  main_v_r, skid_v_r;
  logic  adv;

  assign adv           = !skid_v_r;
  assign in_chan.ready = adv;

  always_comb begin
    logic signed [DATA_WIDTH-1:0] a, b;
    logic [DATA_WIDTH-1:0]        ma, mb;
    logic signed [DATA_WIDTH:0]   sum;
    logic                         sum_ovf;
    logic [REM_W-1:0]             r_sh;
    logic                         q_bit;

    // stage 0: magnitudes and divider operands
    a  = in_chan.operand_a;
    b  = in_chan.operand_b;
    ma = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
    mb = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
    s_nxt[0]      = '0;
    s_nxt[0].cmd  = in_chan.command;
    s_nxt[0].a    = a;
    s_nxt[0].b    = b;
    s_nxt[0].ma   = ma;
    s_nxt[0].mb   = mb;
    s_nxt[0].neg  = a[DATA_WIDTH-1] != b[DATA_WIDTH-1];
    s_nxt[0].num  = (NUM_W'(ma) << (FRAC_BITS + 1)) + NUM_W'(mb);
    s_nxt[0].den  = {mb, 1'b0};

    // stage 1: product and the add, compare, min/max and conversion commands
    a   = s_r[0].a;
    b   = s_r[0].b;
    sum = '0;
    s_nxt[1]      = s_r[0];
    s_nxt[1].prod = PROD_W'(s_r[0].ma) * PROD_W'(s_r[0].mb);
    s_nxt[1].dz   = s_r[0].mb == '0;
    s_nxt[1].sres = '0;
    s_nxt[1].lt   = 1'b0;
    s_nxt[1].eq   = 1'b0;
    s_nxt[1].gt   = 1'b0;
    s_nxt[1].ovf  = 1'b0;
    case (s_r[0].cmd)
      CMD_ADD: sum = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
      CMD_SUB: sum = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
      CMD_INC: sum = {a[DATA_WIDTH-1], a} + (DATA_WIDTH+1)'(1);
      CMD_DEC: sum = {a[DATA_WIDTH-1], a} - (DATA_WIDTH+1)'(1);
      default: sum = '0;
    endcase
    sum_ovf = sum[DATA_WIDTH] != sum[DATA_WIDTH-1];
    case (s_r[0].cmd) inside
      CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC: begin
        s_nxt[1].ovf  = sum_ovf;
        s_nxt[1].sres = !sum_ovf ? sum[DATA_WIDTH-1:0] :
                        (sum[DATA_WIDTH] ? SAT_MIN : SAT_MAX);
      end
      CMD_CMP: begin
        s_nxt[1].lt = a < b;
        s_nxt[1].eq = a == b;
        s_nxt[1].gt = a > b;
      end
      CMD_MIN: s_nxt[1].sres = (a < b) ? a : b;
      CMD_MAX: s_nxt[1].sres = (a > b) ? a : b;
      CMD_FROMINT: begin
        // fits only if the bits shifted out all match the sign
        if (a[DATA_WIDTH-1:DATA_WIDTH-1-FRAC_BITS] == '0 ||
            a[DATA_WIDTH-1:DATA_WIDTH-1-FRAC_BITS] == '1) begin
          s_nxt[1].sres = a <<< FRAC_BITS;
        end else begin
          s_nxt[1].ovf  = 1'b1;
          s_nxt[1].sres = a[DATA_WIDTH-1] ? SAT_MIN : SAT_MAX;
        end
      end
      CMD_TOINT: s_nxt[1].sres = a >>> FRAC_BITS;
      default: s_nxt[1].sres = '0;
    endcase

    // stages 2 and up: one restoring divide step each
    for (int k = 2; k < STAGES; k++) begin
      r_sh  = {s_r[k-1].rem[REM_W-2:0], s_r[k-1].num[NUM_W-1]};
      q_bit = r_sh >= {1'b0, s_r[k-1].den};
      s_nxt[k]     = s_r[k-1];
      s_nxt[k].rem = q_bit ? (r_sh - {1'b0, s_r[k-1].den}) : r_sh;
      s_nxt[k].num = {s_r[k-1].num[NUM_W-2:0], 1'b0};
      s_nxt[k].quo = {s_r[k-1].quo[NUM_W-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < STAGES; k++) begin
        s_r[k] <= s_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STAGES; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= in_chan.valid;
      for (int k = 1; k < STAGES; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  // final rounding, saturation and selection
  always_comb begin
    logic [PROD_W-1:0] mm, lim;
    pipe_t p;
    p   = s_r[STAGES-1];
    lim = p.neg ? PROD_W'(SAT_MIN) : PROD_W'(SAT_MAX);
    mm  = '0;
    fin = '0;
    case (p.cmd) inside
      CMD_MUL, CMD_DIV: begin
        if (p.cmd == CMD_MUL) begin
          mm = (p.prod + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        end else begin
          mm = PROD_W'(p.quo);
        end
        if (p.cmd == CMD_DIV && p.dz) begin
          fin.divide_by_zero = 1'b1;
        end else begin
          if (mm > lim) begin
            mm           = lim;
            fin.overflow = 1'b1;
          end
          fin.result = p.neg ? (~mm[DATA_WIDTH-1:0] + 1'b1) : mm[DATA_WIDTH-1:0];
        end
      end
      default: begin
        fin.result   = p.sres;
        fin.less     = p.lt;
        fin.equal    = p.eq;
        fin.greater  = p.gt;
        fin.overflow = p.ovf;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (main_v_r && !out_chan.ready) begin
      if (adv && v_r[STAGES-1]) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      main_v_r <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= v_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (main_v_r && !out_chan.ready) begin
      if (adv) begin
        skid_r <= fin;
      end
    end else if (skid_v_r) begin
      main_r <= skid_r;
    end else begin
      main_r <= fin;
    end
  end

  assign out_chan.valid          = main_v_r;
  assign out_chan.result         = main_r.result;
  assign out_chan.less           = main_r.less;
  assign out_chan.equal          = main_r.equal;
  assign out_chan.greater        = main_r.greater;
  assign out_chan.overflow       = main_r.overflow;
  assign out_chan.divide_by_zero = main_r.divide_by_zero;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held without a main entry");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> v_r[0])
    else $error("accepted item missing from first stage");

  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> $onehot0({out_chan.less, out_chan.equal, out_chan.greater}))
    else $error("more than one compare flag set");

  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.divide_by_zero) |->
      (out_chan.result == '0 && !out_chan.overflow))
    else $error("divide by zero with nonzero result or overflow");

endmodule

`default_nettype wire

[tb/sv/fixed_point_q24_8_alu_tb.sv]
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_tb
// Drives commands into the Q24.8 unit with random gaps on both channels and
// checks every result and flag against typed table values or an in-bench model.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_q24_8_alu_tb;
  import fpalu_pkg::*;

  logic clk;
  logic rst_n;
  logic failed;

  fpalu_in_if  in_chan ();
  fpalu_out_if out_chan ();

  fixed_point_q24_8_alu dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  typedef struct {
    logic [3:0]         cmd;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               known;  // expected result typed in the row
    res_t               res;
  } row_t;

  res_t result_queue[$];
  row_t rows[$];

  localparam longint LMAX = 64'sd2147483647;
  localparam longint LMIN = -64'sd2147483648;

  function automatic longint clamp(input longint v, inout logic ovf);
    if (v > LMAX) begin
      ovf = 1'b1;
      return LMAX;
    end
    if (v < LMIN) begin
      ovf = 1'b1;
      return LMIN;
    end
    return v;
  endfunction

  // magnitude with sign applied, saturating
  function automatic longint apply_sign(input logic [63:0] m, input logic neg,
                                        inout logic ovf);
    logic [63:0] lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (m > lim) begin
      ovf = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic res_t alu_predict(input logic [3:0] cmd, input logic signed [31:0] a32,
                                       input logic signed [31:0] b32);
    res_t r;
    longint a, b, v;
    logic [63:0] ma, mb, m;
    logic neg, ovf;
    a = a32;
    b = b32;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    ovf = 1'b0;
    v = 0;
    r = '0;
    case (cmd)
      CMD_ADD: v = clamp(a + b, ovf);
      CMD_SUB: v = clamp(a - b, ovf);
      CMD_MUL: begin
        m = (ma * mb + 64'd128) >> 8;
        v = apply_sign(m, neg, ovf);
      end
      CMD_DIV: begin
        if (b == 0) r.divide_by_zero = 1'b1;
        else begin
          m = ((ma << 8) * 2 + mb) / (2 * mb);
          v = apply_sign(m, neg, ovf);
        end
      end
      CMD_CMP: begin
        r.less = a < b;
        r.equal = a == b;
        r.greater = a > b;
      end
      CMD_MIN: v = a < b ? a : b;
      CMD_MAX: v = a > b ? a : b;
      CMD_INC: v = clamp(a + 1, ovf);
      CMD_DEC: v = clamp(a - 1, ovf);
      CMD_FROMINT: v = clamp(a * 256, ovf);
      CMD_TOINT: v = a >>> 8;
      default: v = 0;
    endcase
    r.result = v[31:0];
    r.overflow = ovf;
    return r;
  endfunction

  function automatic res_t mk(input logic [31:0] v, input logic [4:0] f);
    res_t r;
    r.result = v;
    {r.less, r.equal, r.greater, r.overflow, r.divide_by_zero} = f;
    return r;
  endfunction

  task automatic add_row(input logic [3:0] c, input logic [31:0] a, input logic [31:0] b,
                         input logic known, input res_t r);
    row_t w;
    w.cmd = c;
    w.a = a;
    w.b = b;
    w.known = known;
    w.res = r;
    rows.push_back(w);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom)};
      1: return 32'($signed($urandom_range(0, 2047)) - 1024);
      2: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                     : 32'h80000000 + $urandom_range(0, 3);
      3: return {{16{$urandom_range(0, 1) ? 1'b1 : 1'b0}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // drops valid only when a gap really follows
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3)
                                                              : $urandom_range(10, 60));
    if (n > 0) begin
      in_chan.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_item(input logic [3:0] c, input logic [31:0] a, input logic [31:0] b,
                           input logic known, input res_t r);
    res_t p;
    p = alu_predict(c, a, b);
    if (known && p !== r)
      $display("%0t table row disagrees with model: cmd %0d exp %h model %h",
               $time, c, r, p);
    in_chan.valid <= 1'b1;
    in_chan.command <= c;
    in_chan.operand_a <= a;
    in_chan.operand_b <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    result_queue.push_back(known ? r : p);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("TEST FAILED");
    $finish;
  end

  // result sink with random stalls
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 19) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(5, 50)) @(negedge clk);
      end
      out_chan.ready <= $urandom_range(0, 3) != 0;
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.result = out_chan.result;
      got.less = out_chan.less;
      got.equal = out_chan.equal;
      got.greater = out_chan.greater;
      got.overflow = out_chan.overflow;
      got.divide_by_zero = out_chan.divide_by_zero;
      if (result_queue.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, got);
        failed <= 1'b1;
      end else begin
        if (got !== result_queue[0]) begin
          $display("%0t mismatch: expected %h actual %h", $time, result_queue[0], got);
          failed <= 1'b1;
        end
        void'(result_queue.pop_front());
      end
    end
  end

  initial begin
    logic [3:0] c;
    int k;
    failed = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.command = '0;
    in_chan.operand_a = '0;
    in_chan.operand_b = '0;

    // flags: less, equal, greater, overflow, divide_by_zero
    add_row(CMD_ADD, 32'h7fffffff, 32'h1, 1'b1, mk(32'h7fffffff, 5'b00010));
    add_row(CMD_ADD, 32'h80000000, 32'hffffffff, 1'b1, mk(32'h80000000, 5'b00010));
    add_row(CMD_SUB, 32'h80000000, 32'h1, 1'b1, mk(32'h80000000, 5'b00010));
    add_row(CMD_SUB, 32'h7fffffff, 32'h80000000, 1'b1, mk(32'h7fffffff, 5'b00010));
    add_row(CMD_MUL, 32'h80000000, 32'h80000000, 1'b1, mk(32'h7fffffff, 5'b00010));
    add_row(CMD_MUL, 32'h00000180, 32'h00000080, 1'b0, '0);
    add_row(CMD_MUL, 32'hfffffe80, 32'h00000080, 1'b0, '0);
    add_row(CMD_DIV, 32'h00000100, 32'h0, 1'b1, mk(32'h0, 5'b00001));
    add_row(CMD_DIV, 32'h80000000, 32'hffffff00, 1'b1, mk(32'h7fffffff, 5'b00010));
    add_row(CMD_DIV, 32'h00000001, 32'h00000200, 1'b0, '0);
    add_row(CMD_DIV, 32'hffffffff, 32'h00000200, 1'b0, '0);
    add_row(CMD_CMP, 32'h80000000, 32'h7fffffff, 1'b1, mk(32'h0, 5'b10000));
    add_row(CMD_CMP, 32'h12345678, 32'h12345678, 1'b1, mk(32'h0, 5'b01000));
    add_row(CMD_CMP, 32'h7fffffff, 32'h80000000, 1'b1, mk(32'h0, 5'b00100));
    add_row(CMD_MIN, 32'h80000000, 32'h7fffffff, 1'b1, mk(32'h80000000, 5'b00000));
    add_row(CMD_MAX, 32'h80000000, 32'h7fffffff, 1'b1, mk(32'h7fffffff, 5'b00000));
    add_row(CMD_MIN, 32'h5, 32'h5, 1'b1, mk(32'h5, 5'b00000));
    add_row(CMD_INC, 32'h7fffffff, 32'h0, 1'b1, mk(32'h7fffffff, 5'b00010));
    add_row(CMD_DEC, 32'h80000000, 32'hffffffff, 1'b1, mk(32'h80000000, 5'b00010));
    add_row(CMD_FROMINT, 32'h00800000, 32'h0, 1'b1, mk(32'h7fffffff, 5'b00010));
    add_row(CMD_FROMINT, 32'hff7fffff, 32'h0, 1'b1, mk(32'h80000000, 5'b00010));
    add_row(CMD_TOINT, 32'hffffff01, 32'h0, 1'b1, mk(32'hffffffff, 5'b00000));
    add_row(CMD_TOINT, 32'h7fffffff, 32'h0, 1'b1, mk(32'h007fffff, 5'b00000));
    add_row(4'd11, 32'hffffffff, 32'hffffffff, 1'b1, mk(32'h0, 5'b00000));
    add_row(4'd15, 32'h7fffffff, 32'h1, 1'b1, mk(32'h0, 5'b00000));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_item(rows[i].cmd, rows[i].a, rows[i].b, rows[i].known,
                                rows[i].res);
    in_chan.valid <= 1'b0;
    // drain fully before the random part
    while (result_queue.size() != 0) @(negedge clk);

    for (k = 0; k < 1000; k++) begin
      if (k % 200 == 100) begin
        // a burst of back-to-back items without gaps
        repeat (30) begin
          c = 4'($urandom_range(0, 10));
          send_item(c, rand_operand(), rand_operand(), 1'b0, '0);
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        idle_gap();
      end
      c = $urandom_range(0, 19) == 0 ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
      send_item(c, rand_operand(), $urandom_range(0, 15) == 0 ? 32'h0 : rand_operand(),
                1'b0, '0);
      if (k == 500) begin
        in_chan.valid <= 1'b0;
        while (result_queue.size() != 0) @(negedge clk);
      end
    end
    in_chan.valid <= 1'b0;

    while (result_queue.size() != 0) @(negedge clk);
    repeat (3 * (STAGES + 1)) @(negedge clk);
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/fpalu_pkg.sv
hw/rtl/fpalu_in_if.sv
hw/rtl/fpalu_out_if.sv
hw/rtl/fixed_point_q24_8_alu.sv
tb/sv/fixed_point_q24_8_alu_tb.sv
